/* rtl/core/force_heatmap_hsv_to_rgb_defines.svh */
// Assertion macros for the force heat-map colorizer.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef FORCE_HEATMAP_HSV_TO_RGB_DEFINES_SVH
`define FORCE_HEATMAP_HSV_TO_RGB_DEFINES_SVH

// Check a property on every rising clock edge outside reset
`define FHSV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside reset
`define FHSV_ASSERT_NEVER(lbl, cond, msg) \
  `FHSV_ASSERT(lbl, !(cond), msg)

`endif

/* rtl/core/fhsv_pkg.sv */
// Shared constants and types of the force heat-map colorizer.
// No dependencies; imported by the divider cells, the color back end and the top level.
package fhsv_pkg;

  // Fraction bits of the normalized force and of the hue
  localparam int unsigned HUE_FRAC_BITS = 16;
  localparam int unsigned HueW          = HUE_FRAC_BITS;
  localparam int unsigned NormW         = HUE_FRAC_BITS + 1;

  // Fixed field widths
  localparam int unsigned ForceW = 32;
  localparam int unsigned SpanW  = 16;
  localparam int unsigned UnitW  = 9;
  localparam int unsigned ChanW  = 8;

  // Number of hue sectors
  localparam int unsigned Sectors = 6;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 4;
  localparam logic [CfgIdxW-1:0] CFG_MAX_FORCE  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_HUE_SPAN   = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CFG_SATURATION = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CFG_BRIGHTNESS = CfgIdxW'(3);

  // Register reset values
  localparam logic [ForceW-1:0] MAX_FORCE_RST  = ForceW'(65536);
  localparam logic [SpanW-1:0]  HUE_SPAN_RST   = SpanW'(42598);
  localparam logic [UnitW-1:0]  SATURATION_RST = UnitW'(256);
  localparam logic [UnitW-1:0]  BRIGHTNESS_RST = UnitW'(256);
  localparam logic [UnitW-1:0]  UNIT_FULL      = UnitW'(256);

  // Request traveling down the divider chain
  typedef struct packed {
    logic              vld;
    logic              full;
    logic [ForceW-1:0] rem;
    logic [HueW-1:0]   quo;
  } div_t;

  // Saturate a 1.0-based unit value to 1.0
  function automatic logic [UnitW-1:0] clamp_unit(input logic [UnitW-1:0] val);
    clamp_unit = (val > UNIT_FULL) ? UNIT_FULL : val;
  endfunction

endpackage

/* rtl/core/force_heatmap_hsv_to_rgb.sv */
// Top level of the force heat-map colorizer: config registers, divider chain, color back end.
// Depends on fhsv_pkg, fhsv_div_cell, fhsv_color and force_heatmap_hsv_to_rgb_defines.svh.
//
//   channel  direction  handshake                 payload
//   input    in         in_valid_i / in_stall_o   force_req_i
//   output   out        out_valid_o / out_stall_i red_o, green_o, blue_o
//   config   in         cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One request per cycle unless the pipe is held; stages: one input stage, one divider cell per
// hue fraction bit (16), and five color stages (hue, sector, f*S, channels, select).
// The whole pipe holds while a result waits under out_stall_i; in_stall_o follows it.
// Reset clears all valid flags and loads the register reset values; no clearing pass.
// Config writes are always ready and take effect on the next cycle.
`include "force_heatmap_hsv_to_rgb_defines.svh"

module force_heatmap_hsv_to_rgb (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [fhsv_pkg::ForceW-1:0]  force_req_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [fhsv_pkg::ChanW-1:0]   red_o,
  output logic [fhsv_pkg::ChanW-1:0]   green_o,
  output logic [fhsv_pkg::ChanW-1:0]   blue_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [fhsv_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [fhsv_pkg::ForceW-1:0]  cfg_data_i
);
  import fhsv_pkg::*;

  logic [ForceW-1:0] max_force_q;
  logic [SpanW-1:0]  hue_span_q;
  logic [UnitW-1:0]  sat_q, bri_q;
  logic [UnitW-1:0]  sat_c, bri_c;
  logic              advance;
  div_t              div_s [HueW+1];
  logic              in_vld_q;
  logic              in_full_q;
  logic [ForceW-1:0] in_rem_q;
  logic [NormW-1:0]  norm;
  logic [16:0]       vv_chk;
  logic [ChanW-1:0]  vc_chk;
  logic              in_fire;
  logic              vc_seen;

  assign cfg_ready_o = 1'b1;

  // Decode configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_force_q <= MAX_FORCE_RST;
      hue_span_q  <= HUE_SPAN_RST;
      sat_q       <= SATURATION_RST;
      bri_q       <= BRIGHTNESS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_MAX_FORCE:  max_force_q <= cfg_data_i;
        CFG_HUE_SPAN:   hue_span_q  <= cfg_data_i[SpanW-1:0];
        CFG_SATURATION: sat_q       <= cfg_data_i[UnitW-1:0];
        CFG_BRIGHTNESS: bri_q       <= cfg_data_i[UnitW-1:0];
        default: ;
      endcase
    end
  end

  assign sat_c = clamp_unit(sat_q);
  assign bri_c = clamp_unit(bri_q);

  // Move the whole pipe unless a finished result is held
  assign advance    = !out_valid_o || !out_stall_i;
  assign in_stall_o = !advance;

  // Take the request and flag full scale
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (advance) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      in_full_q <= (max_force_q == '0) || (force_req_i >= max_force_q);
      in_rem_q  <= force_req_i;
    end
  end

  always_comb begin
    div_s[0].vld  = in_vld_q;
    div_s[0].full = in_full_q;
    div_s[0].rem  = in_rem_q;
    div_s[0].quo  = '0;
  end

  // Divider chain, one quotient bit per cell
  for (genvar i = 0; i < HueW; i++) begin : g_div
    fhsv_div_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .en_i        (advance),
      .max_force_i (max_force_q),
      .req_i       (div_s[i]),
      .req_o       (div_s[i+1])
    );
  end

  assign norm = div_s[HueW].full ? (NormW'(1) << HueW) : {1'b0, div_s[HueW].quo};

  // Hue, sectors and channel select
  fhsv_color u_color (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (advance),
    .vld_i      (div_s[HueW].vld),
    .norm_i     (norm),
    .hue_span_i (hue_span_q),
    .sat_i      (sat_c),
    .bri_i      (bri_c),
    .vld_o      (out_valid_o),
    .red_o      (red_o),
    .green_o    (green_o),
    .blue_o     (blue_o)
  );

  // Brightness level that one channel of every sector carries
  assign vv_chk  = 17'(bri_c) * 17'(255);
  assign vc_chk  = vv_chk[15:8];
  assign vc_seen = (red_o == vc_chk) || (green_o == vc_chk) || (blue_o == vc_chk);
  assign in_fire = in_valid_i && !in_stall_o;

  `FHSV_ASSERT(a_in_enters_chain, in_fire |=> div_s[0].vld, "request lost at chain entry")
  `FHSV_ASSERT(a_chain_holds, !advance |=> $stable(div_s[HueW].vld), "chain moved under stall")
  `FHSV_ASSERT_NEVER(a_value_channel, out_valid_o && !vc_seen, "no brightness channel")

endmodule

/* rtl/core/fhsv_div_cell.sv */
// One cell of the restoring divider chain: one quotient bit per cell.
// Depends on fhsv_pkg for the chain request type.
module fhsv_div_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic [fhsv_pkg::ForceW-1:0] max_force_i,
  input  fhsv_pkg::div_t              req_i,
  output fhsv_pkg::div_t              req_o
);
  import fhsv_pkg::*;

  logic [ForceW:0]   rem2;
  logic              ge;
  logic [ForceW-1:0] rem_sub;
  logic              vld_q;
  logic              full_q;
  logic [ForceW-1:0] rem_q;
  logic [HueW-1:0]   quo_q;

  // Shift the remainder and try one subtraction
  always_comb begin
    rem2    = {req_i.rem, 1'b0};
    ge      = (rem2 >= {1'b0, max_force_i});
    rem_sub = ge ? ForceW'(rem2 - {1'b0, max_force_i}) : rem2[ForceW-1:0];
  end

  // Advance the valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= req_i.vld;
    end
  end

  // Advance the payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      full_q <= req_i.full;
      rem_q  <= rem_sub;
      quo_q  <= {req_i.quo[HueW-2:0], ge};
    end
  end

  assign req_o = '{vld: vld_q, full: full_q, rem: rem_q, quo: quo_q};

endmodule

/* rtl/core/fhsv_color.sv */
// Color back end: hue from the normalized force, sector split, p/q/t channels, RGB select.
// Depends on fhsv_pkg for widths and constants.
module fhsv_color (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        vld_i,
  input  logic [fhsv_pkg::NormW-1:0]  norm_i,
  input  logic [fhsv_pkg::SpanW-1:0]  hue_span_i,
  input  logic [fhsv_pkg::UnitW-1:0]  sat_i,
  input  logic [fhsv_pkg::UnitW-1:0]  bri_i,
  output logic                        vld_o,
  output logic [fhsv_pkg::ChanW-1:0]  red_o,
  output logic [fhsv_pkg::ChanW-1:0]  green_o,
  output logic [fhsv_pkg::ChanW-1:0]  blue_o
);
  import fhsv_pkg::*;

  localparam int unsigned HueProdW = NormW + SpanW;
  localparam int unsigned H6W      = HueW + 3;
  localparam int unsigned XW       = HueW + 9;
  localparam int unsigned VvW      = 17;
  localparam int unsigned PW       = XW + VvW;
  localparam logic [NormW-1:0] ONE        = NormW'(1) << HueW;
  localparam logic [XW-1:0]    UNIT_SCALE = XW'(1) << (HueW + 8);

  logic              vld_a_q, vld_b_q, vld_c_q, vld_d_q, vld_e_q;
  logic [HueW-1:0]   hue_a_q;
  logic [2:0]        sec_b_q, sec_c_q, sec_d_q;
  logic [HueW-1:0]   frac_b_q;
  logic [XW-1:0]     fs_c_q;
  logic [ChanW-1:0]  p_d_q, q_d_q, t_d_q;
  logic [ChanW-1:0]  red_q, green_q, blue_q;

  logic [NormW-1:0]  one_minus_n;
  logic [HueProdW-1:0] hue_prod;
  logic [H6W-1:0]    h6;
  logic [XW-1:0]     fs;
  logic [XW-1:0]     sone, xp, xq, xt;
  logic [VvW-1:0]    vv;
  logic [PW-1:0]     pp, pq, pt;
  logic [ChanW-1:0]  vc;

  // Hue = (1 - n) * span
  always_comb begin
    one_minus_n = ONE - norm_i;
    hue_prod    = HueProdW'(one_minus_n) * HueProdW'(hue_span_i);
  end

  // Six sectors
  assign h6 = H6W'(hue_a_q) * H6W'(Sectors);

  // Sector fraction times saturation
  assign fs = XW'(frac_b_q) * XW'(sat_i);

  // Channel levels scaled by 255 * V
  always_comb begin
    vv   = VvW'(bri_i) * VvW'(255);
    vc   = vv[15:8];
    sone = XW'(sat_i) << HueW;
    xp   = UNIT_SCALE - sone;
    xq   = UNIT_SCALE - fs_c_q;
    xt   = UNIT_SCALE - (sone - fs_c_q);
    pp   = PW'(vv) * PW'(xp);
    pq   = PW'(vv) * PW'(xq);
    pt   = PW'(vv) * PW'(xt);
  end

  // Advance the valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      vld_c_q <= 1'b0;
      vld_d_q <= 1'b0;
      vld_e_q <= 1'b0;
    end else if (en_i) begin
      vld_a_q <= vld_i;
      vld_b_q <= vld_a_q;
      vld_c_q <= vld_b_q;
      vld_d_q <= vld_c_q;
      vld_e_q <= vld_d_q;
    end
  end

  // Advance the payload and pick the channel order of the sector
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hue_a_q  <= hue_prod[HueW+15:16];
      sec_b_q  <= h6[H6W-1:HueW];
      frac_b_q <= h6[HueW-1:0];
      sec_c_q  <= sec_b_q;
      fs_c_q   <= fs;
      sec_d_q  <= sec_c_q;
      p_d_q    <= pp[HueW+23:HueW+16];
      q_d_q    <= pq[HueW+23:HueW+16];
      t_d_q    <= pt[HueW+23:HueW+16];
      case (sec_d_q)
        3'd0: begin red_q <= vc;    green_q <= t_d_q; blue_q <= p_d_q; end
        3'd1: begin red_q <= q_d_q; green_q <= vc;    blue_q <= p_d_q; end
        3'd2: begin red_q <= p_d_q; green_q <= vc;    blue_q <= t_d_q; end
        3'd3: begin red_q <= p_d_q; green_q <= q_d_q; blue_q <= vc;    end
        3'd4: begin red_q <= t_d_q; green_q <= p_d_q; blue_q <= vc;    end
        default: begin red_q <= vc; green_q <= p_d_q; blue_q <= q_d_q; end
      endcase
    end
  end

  assign vld_o   = vld_e_q;
  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for force_heatmap_hsv_to_rgb: directed table, then random phases.
// Depends on fhsv_pkg and the RTL top level; predicts colors with a local HSV model or the table.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fhsv_pkg::*;

  localparam int unsigned RunLimit = 400000;
  localparam int unsigned Latency  = 22;
  localparam int unsigned Phases   = 10;
  localparam int unsigned PerPhase = 100;
  localparam logic [CfgIdxW-1:0] CFG_SPARE = CFG_BRIGHTNESS + CfgIdxW'(1);

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } color_t;

  typedef enum logic {ROW_FORCE, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic [CfgIdxW-1:0] idx;
    logic [ForceW-1:0] data;
    logic              fixed;
    color_t            want;
  } row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [ForceW-1:0]  force_req_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [ChanW-1:0]   red_o;
  logic [ChanW-1:0]   green_o;
  logic [ChanW-1:0]   blue_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [ForceW-1:0]  cfg_data_i;

  // Local copy of the register file
  logic [ForceW-1:0] cur_max_force = MAX_FORCE_RST;
  logic [SpanW-1:0]  cur_hue_span  = HUE_SPAN_RST;
  logic [UnitW-1:0]  cur_sat       = SATURATION_RST;
  logic [UnitW-1:0]  cur_bright    = BRIGHTNESS_RST;

  color_t pending_colors[$];
  row_t   stim_table[$];
  int     mismatches = 0;
  int     tx_odds    = 0;
  int     rx_odds    = 0;
  logic   typed_on   = 1'b0;
  color_t typed_color = '0;

  force_heatmap_hsv_to_rgb i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .force_req_i (force_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Generate the clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Abort a hung run
  initial begin
    repeat (RunLimit) @(posedge clk_i);
    $display("force_heatmap_hsv_to_rgb test failed");
    $finish;
  end

  // One shaded channel: 255 * v * (256*one - g*s) / (2^16 * one), truncated to 8 bits
  function automatic logic [ChanW-1:0] shade(input logic [63:0] v, input logic [63:0] s,
                                             input logic [63:0] g);
    logic [63:0] one;
    logic [63:0] num;
    one = 64'd1 << HUE_FRAC_BITS;
    num = 64'd255 * v * (64'd256 * one - g * s);
    return ChanW'(num / (64'd65536 * one));
  endfunction

  // Predict the color for one force under the current registers
  function automatic color_t colorize(input logic [ForceW-1:0] frc);
    logic [63:0] one, norm, hue, h6, sector, frac, s, v;
    logic [ChanW-1:0] vc, p, q, t;
    color_t c;
    one = 64'd1 << HUE_FRAC_BITS;
    if (cur_max_force == '0 || frc >= cur_max_force) begin
      norm = one;
    end else begin
      norm = ({32'b0, frc} << HUE_FRAC_BITS) / {32'b0, cur_max_force};
    end
    hue    = ((one - norm) * {48'b0, cur_hue_span}) >> 16;
    h6     = hue * 64'(Sectors);
    sector = h6 >> HUE_FRAC_BITS;
    frac   = h6 & (one - 64'd1);
    s      = (cur_sat > UNIT_FULL) ? 64'(UNIT_FULL) : 64'(cur_sat);
    v      = (cur_bright > UNIT_FULL) ? 64'(UNIT_FULL) : 64'(cur_bright);
    vc     = ChanW'((64'd255 * v) >> 8);
    p      = shade(v, s, one);
    q      = shade(v, s, frac);
    t      = shade(v, s, one - frac);
    case (sector)
      64'd0:   c = '{vc, t, p};
      64'd1:   c = '{q, vc, p};
      64'd2:   c = '{p, vc, t};
      64'd3:   c = '{p, q, vc};
      64'd4:   c = '{t, p, vc};
      default: c = '{vc, p, q};
    endcase
    return c;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("ERROR %0t ns: %s", $realtime, msg);
    mismatches++;
  endtask

  // Predict on input acceptance, compare on output acceptance
  always @(posedge clk_i) begin
    color_t exp;
    color_t nxt;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_colors.size() == 0) begin
          flag_mismatch($sformatf("color %h/%h/%h with no request waiting",
                                  red_o, green_o, blue_o));
        end else begin
          exp = pending_colors.pop_front();
          if (red_o !== exp.red)
            flag_mismatch($sformatf("red %h, want %h", red_o, exp.red));
          if (green_o !== exp.green)
            flag_mismatch($sformatf("green %h, want %h", green_o, exp.green));
          if (blue_o !== exp.blue)
            flag_mismatch($sformatf("blue %h, want %h", blue_o, exp.blue));
        end
      end
      if (in_valid_i && !in_stall_o) begin
        nxt = typed_on ? typed_color : colorize(force_req_i);
        pending_colors.insert(pending_colors.size(), nxt);
      end
    end
  end

  // Stall the result side in random bursts
  initial begin
    int burst;
    out_stall_i <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_odds != 0 && $urandom_range(1, 100) <= rx_odds) begin
        burst = $urandom_range(1, 11);
        out_stall_i <= 1'b1;
        repeat (burst) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Hold until every predicted color has come back
  task automatic drain();
    while (pending_colors.size() != 0) @(posedge clk_i);
  endtask

  // Write one register; the block must be idle
  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [ForceW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_MAX_FORCE:  cur_max_force = data;
      CFG_HUE_SPAN:   cur_hue_span  = data[SpanW-1:0];
      CFG_SATURATION: cur_sat       = data[UnitW-1:0];
      CFG_BRIGHTNESS: cur_bright    = data[UnitW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Send one force request, with an optional gap before it
  task automatic send_force(input logic [ForceW-1:0] frc, input logic fixed, input color_t want);
    int gap;
    if (tx_odds != 0 && $urandom_range(1, 100) <= tx_odds) begin
      gap = $urandom_range(1, 11);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    typed_on    = fixed;
    typed_color = want;
    in_valid_i  <= 1'b1;
    force_req_i <= frc;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic add_force(input logic [ForceW-1:0] frc);
    row_t r;
    r = '{ROW_FORCE, CFG_MAX_FORCE, frc, 1'b0, color_t'('0)};
    stim_table.insert(stim_table.size(), r);
  endtask

  task automatic add_force_exp(input logic [ForceW-1:0] frc, input color_t want);
    row_t r;
    r = '{ROW_FORCE, CFG_MAX_FORCE, frc, 1'b1, want};
    stim_table.insert(stim_table.size(), r);
  endtask

  task automatic add_write(input logic [CfgIdxW-1:0] idx, input logic [ForceW-1:0] data);
    row_t r;
    r = '{ROW_WRITE, idx, data, 1'b0, color_t'('0)};
    stim_table.insert(stim_table.size(), r);
  endtask

  // Any index past the last register
  function automatic logic [CfgIdxW-1:0] CFG_INDEX_RANDOM();
    return CfgIdxW'($urandom_range(int'(CFG_SPARE), (1 << CfgIdxW) - 1));
  endfunction

  initial begin
    int          ph;
    int          k;
    logic [ForceW-1:0] frc;
    logic [ForceW-1:0] pick;
    row_t        row;

    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    force_req_i <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset registers: zero force is blue-ish, full force and beyond are pure red
    add_force_exp(32'd0, '{8'd0, 8'd25, 8'd255});
    add_force_exp(32'd65536, '{8'd255, 8'd0, 8'd0});
    add_force_exp(32'hFFFF_FFFF, '{8'd255, 8'd0, 8'd0});
    add_force(32'd32768);
    add_force(32'd1);
    add_force(32'd65535);
    // Largest max force
    add_write(CFG_MAX_FORCE, 32'hFFFF_FFFF);
    add_force_exp(32'hFFFF_FFFF, '{8'd255, 8'd0, 8'd0});
    add_force(32'hFFFF_FFFE);
    add_force(32'h8000_0000);
    // Zero max force saturates to full scale
    add_write(CFG_MAX_FORCE, 32'd0);
    add_force_exp(32'd0, '{8'd255, 8'd0, 8'd0});
    add_write(CFG_MAX_FORCE, 32'd1);
    add_force_exp(32'd0, '{8'd0, 8'd25, 8'd255});
    // Widest hue span, one force per sector
    add_write(CFG_MAX_FORCE, 32'd1000);
    add_write(CFG_HUE_SPAN, 32'd65535);
    add_force(32'd0);
    add_force(32'd250);
    add_force(32'd400);
    add_force(32'd600);
    add_force(32'd750);
    add_force(32'd900);
    add_write(CFG_HUE_SPAN, 32'd0);
    add_force_exp(32'd0, '{8'd255, 8'd0, 8'd0});
    // No saturation gives white; brightness above 1.0 clamps
    add_write(CFG_HUE_SPAN, 32'(HUE_SPAN_RST));
    add_write(CFG_SATURATION, 32'd0);
    add_write(CFG_BRIGHTNESS, 32'd511);
    add_force_exp(32'd0, '{8'd255, 8'd255, 8'd255});
    add_write(CFG_BRIGHTNESS, 32'd0);
    add_force_exp(32'd5, '{8'd0, 8'd0, 8'd0});
    add_write(CFG_SATURATION, 32'd511);
    add_write(CFG_BRIGHTNESS, 32'd128);
    add_force(32'd0);
    // Write to an unused index must change nothing
    add_write(CFG_SPARE, 32'hFFFF_FFFF);
    add_force(32'd0);

    // Walk the table with moderate idling
    tx_odds = 20;
    rx_odds = 15;
    foreach (stim_table[i]) begin
      row = stim_table[i];
      if (row.kind == ROW_WRITE) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        drain();
        cfg_write(row.idx, row.data);
      end else begin
        send_force(row.data, row.fixed, row.want);
      end
    end

    // Random phases, each with fresh registers; the last runs without idling
    for (ph = 0; ph < Phases; ph++) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      typed_on = 1'b0;
      drain();
      case ($urandom_range(0, 5))
        0:       pick = 32'd0;
        1:       pick = 32'd1;
        2:       pick = $urandom_range(2, 4096);
        3:       pick = MAX_FORCE_RST;
        4:       pick = $urandom;
        default: pick = 32'hFFFF_FFFF;
      endcase
      cfg_write(CFG_MAX_FORCE, pick);
      case ($urandom_range(0, 2))
        0:       pick = 32'd0;
        1:       pick = 32'd65535;
        default: pick = $urandom;
      endcase
      cfg_write(CFG_HUE_SPAN, pick);
      cfg_write(CFG_SATURATION, ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 256));
      cfg_write(CFG_BRIGHTNESS, ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 256));
      if ($urandom_range(0, 2) == 0)
        cfg_write(CFG_INDEX_RANDOM(), $urandom);
      if (ph == Phases - 1) begin
        tx_odds = 0;
        rx_odds = 0;
      end else begin
        case ($urandom_range(0, 3))
          0:       tx_odds = 0;
          1:       tx_odds = 10;
          2:       tx_odds = 30;
          default: tx_odds = 60;
        endcase
        case ($urandom_range(0, 3))
          0:       rx_odds = 0;
          1:       rx_odds = 10;
          2:       rx_odds = 30;
          default: rx_odds = 60;
        endcase
      end
      for (k = 0; k < PerPhase; k++) begin
        case ($urandom_range(0, 7))
          0:       frc = $urandom;
          1:       frc = 32'd0;
          2:       frc = 32'hFFFF_FFFF;
          3:       frc = (cur_max_force == '0) ? '0 : cur_max_force - ForceW'(1);
          4:       frc = cur_max_force;
          default: frc = (cur_max_force == '0) ? $urandom : $urandom_range(0, cur_max_force);
        endcase
        send_force(frc, 1'b0, color_t'('0));
      end
    end

    // Drop valid, wait out the pipe, then judge
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    drain();
    repeat (Latency + 8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("force_heatmap_hsv_to_rgb test passed");
    end else begin
      $display("force_heatmap_hsv_to_rgb test failed");
    end
    $finish;
  end

endmodule
